/* sv/c_subset_tokenizer_core_defines.svh */
// Assertion macros shared by the tokenizer checker.
// Stand-alone header; no dependencies.
`ifndef C_SUBSET_TOKENIZER_CORE_DEFINES_SVH
`define C_SUBSET_TOKENIZER_CORE_DEFINES_SVH

// Clocked property, ignored while reset is asserted.
`define CST_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Clocked property that also holds during reset.
`define CST_ASSERT_ALWAYS(lbl, ck, prop, msg) \
    lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

/* sv/cst_pkg.sv */
// Shared types and constants for the C subset tokenizer.
// No dependencies; imported by the core and its checker.
package cst_pkg;

    localparam int CST_LINE_BITS   = 16;
    localparam int CST_COL_BITS    = 16;
    localparam int CST_OFFSET_BITS = 24;
    localparam int CST_VALUE_BITS  = 32;

    // result queue depth, power of two so pointers wrap on their own
    localparam int CST_QDEPTH = 4;

    typedef enum logic [3:0] {
        TKN_INT     = 4'd0,
        TKN_RETURN  = 4'd1,
        TKN_NAME    = 4'd2,
        TKN_NUMBER  = 4'd3,
        TKN_ADD     = 4'd4,
        TKN_SUB     = 4'd5,
        TKN_MUL     = 4'd6,
        TKN_DIV     = 4'd7,
        TKN_EQUALS  = 4'd8,
        TKN_PAREN_L = 4'd9,
        TKN_PAREN_R = 4'd10,
        TKN_BRACE_L = 4'd11,
        TKN_BRACE_R = 4'd12,
        TKN_SEMI    = 4'd13,
        TKN_END     = 4'd14,
        TKN_BAD     = 4'd15
    } token_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_IDENT  = 3'b010,
        MODE_NUMBER = 3'b100
    } scan_mode_t;

    // keyword prefix tracker codes
    localparam logic [3:0] KW_DEAD   = 4'd0;
    localparam logic [3:0] KW_I      = 4'd1;
    localparam logic [3:0] KW_IN     = 4'd2;
    localparam logic [3:0] KW_INT    = 4'd3;
    localparam logic [3:0] KW_R      = 4'd4;
    localparam logic [3:0] KW_RE     = 4'd5;
    localparam logic [3:0] KW_RET    = 4'd6;
    localparam logic [3:0] KW_RETU   = 4'd7;
    localparam logic [3:0] KW_RETUR  = 4'd8;
    localparam logic [3:0] KW_RETURN = 4'd9;

    localparam logic [7:0] CH_LF = 8'h0A;

endpackage

/* sv/c_subset_tokenizer_core.sv */
// Streaming tokenizer for a small C subset, one source byte per item.
// The input register takes a new item every cycle while at most two tokens wait in the
// four-entry result queue, since one item can yield two tokens. An item that both ends a
// pending identifier or literal and yields its own token puts both tokens into the queue,
// which hands them to the outputs one after the other. The first token of an item passes
// through the input register and then the result queue before it shows on the outputs;
// output stalls back up through the queue into the input register.
// End of text, a zero byte or an error token halts the block until reset.
// Depends on cst_pkg.
module c_subset_tokenizer_core
    import cst_pkg::*;
#(
    parameter int LINE_BITS   = CST_LINE_BITS,
    parameter int COL_BITS    = CST_COL_BITS,
    parameter int OFFSET_BITS = CST_OFFSET_BITS,
    parameter int VALUE_BITS  = CST_VALUE_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   kind,
    input  logic [7:0]             char_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [3:0]             token_kind,
    output logic [LINE_BITS-1:0]   token_line,
    output logic [COL_BITS-1:0]    token_column,
    output logic [VALUE_BITS-1:0]  literal_value,
    output logic [OFFSET_BITS-1:0] ident_start,
    output logic [OFFSET_BITS-1:0] ident_length,
    output logic [7:0]             bad_char,
    output logic                   last_of_run
);

    localparam int PTR_W = $clog2(CST_QDEPTH);
    localparam int CNT_W = $clog2(CST_QDEPTH + 1);

    typedef struct packed {
        token_kind_t            kind;
        logic [LINE_BITS-1:0]   line;
        logic [COL_BITS-1:0]    col;
        logic [VALUE_BITS-1:0]  value;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] length;
        logic [7:0]             bad;
        logic                   last;
    } tok_t;

    // input register
    logic       in_full_reg;
    logic       kind_reg;
    logic [7:0] char_reg;

    // scanner state
    scan_mode_t             mode_reg, mode_next;
    logic                   halted_reg, halted_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COL_BITS-1:0]    col_reg, col_next;
    logic [LINE_BITS-1:0]   sline_reg, sline_next;
    logic [COL_BITS-1:0]    scol_reg, scol_next;
    logic [OFFSET_BITS-1:0] soff_reg, soff_next;
    logic [OFFSET_BITS-1:0] rlen_reg, rlen_next;
    logic [VALUE_BITS-1:0]  accum_reg, accum_next;
    logic [3:0]             kw_reg, kw_next;

    // result queue
    tok_t             q_mem [CST_QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_inc;

    logic        go, work;
    logic        is_end, is_letter, is_digit, is_blank, is_punct, is_bad;
    logic        cont_ident, cont_num, cont, pending;
    token_kind_t punct_code;
    logic [3:0]  kw_step;
    logic        has_flush, has_second, pop;
    tok_t        flush_tok, second_tok;

    // ---------------- input stage ----------------
    assign go       = in_full_reg && (count_reg <= CNT_W'(CST_QDEPTH - 2));
    assign in_stall = in_full_reg && !go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            kind_reg <= kind;
            char_reg <= char_byte;
        end
    end

    // ---------------- classification ----------------
    always_comb
    begin
        is_end    = kind_reg || (char_reg == 8'h00);
        is_letter = (char_reg >= "a" && char_reg <= "z") ||
                    (char_reg >= "A" && char_reg <= "Z") || (char_reg == "_");
        is_digit  = (char_reg >= "0" && char_reg <= "9");
        is_blank  = (char_reg == " ") || (char_reg == 8'h09) ||
                    (char_reg == 8'h0D) || (char_reg == CH_LF);
        is_punct  = 1'b1;
        case (char_reg)
            "+":     punct_code = TKN_ADD;
            "-":     punct_code = TKN_SUB;
            "*":     punct_code = TKN_MUL;
            "/":     punct_code = TKN_DIV;
            "=":     punct_code = TKN_EQUALS;
            "(":     punct_code = TKN_PAREN_L;
            ")":     punct_code = TKN_PAREN_R;
            "{":     punct_code = TKN_BRACE_L;
            "}":     punct_code = TKN_BRACE_R;
            ";":     punct_code = TKN_SEMI;
            default:
            begin
                punct_code = TKN_BAD;
                is_punct   = 1'b0;
            end
        endcase
        is_bad = !is_blank && !is_punct && !is_letter && !is_digit;

        case (kw_reg)
            KW_I:     kw_step = (char_reg == "n") ? KW_IN     : KW_DEAD;
            KW_IN:    kw_step = (char_reg == "t") ? KW_INT    : KW_DEAD;
            KW_R:     kw_step = (char_reg == "e") ? KW_RE     : KW_DEAD;
            KW_RE:    kw_step = (char_reg == "t") ? KW_RET    : KW_DEAD;
            KW_RET:   kw_step = (char_reg == "u") ? KW_RETU   : KW_DEAD;
            KW_RETU:  kw_step = (char_reg == "r") ? KW_RETUR  : KW_DEAD;
            KW_RETUR: kw_step = (char_reg == "n") ? KW_RETURN : KW_DEAD;
            default:  kw_step = KW_DEAD;
        endcase

        pending    = (mode_reg != MODE_IDLE);
        cont_ident = (mode_reg == MODE_IDENT) && (is_letter || is_digit);
        cont_num   = (mode_reg == MODE_NUMBER) && is_digit;
        cont       = !is_end && (cont_ident || cont_num);
        work       = go && !halted_reg;
        has_flush  = work && pending && !cont;
        has_second = work && (is_end || (!cont && (is_punct || is_bad)));
    end

    // ---------------- token build ----------------
    always_comb
    begin
        flush_tok = '0;
        if (mode_reg == MODE_IDENT)
        begin
            flush_tok.kind   = (kw_reg == KW_INT)    ? TKN_INT :
                               (kw_reg == KW_RETURN) ? TKN_RETURN : TKN_NAME;
            flush_tok.start  = soff_reg;
            flush_tok.length = rlen_reg;
        end
        else
        begin
            flush_tok.kind  = TKN_NUMBER;
            flush_tok.value = accum_reg;
        end
        flush_tok.line = sline_reg;
        flush_tok.col  = scol_reg;
        flush_tok.last = !has_second;

        second_tok      = '0;
        second_tok.line = line_reg;
        second_tok.col  = col_reg;
        second_tok.last = 1'b1;
        if (is_end)
        begin
            second_tok.kind = TKN_END;
        end
        else if (is_punct)
        begin
            second_tok.kind = punct_code;
        end
        else
        begin
            second_tok.kind = TKN_BAD;
            second_tok.bad  = char_reg;
        end
    end

    // ---------------- scanner state update ----------------
    always_comb
    begin
        mode_next   = mode_reg;
        halted_next = halted_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        sline_next  = sline_reg;
        scol_next   = scol_reg;
        soff_next   = soff_reg;
        rlen_next   = rlen_reg;
        accum_next  = accum_reg;
        kw_next     = kw_reg;

        if (work)
        begin
            if (is_end)
            begin
                mode_next   = MODE_IDLE;
                halted_next = 1'b1;
            end
            else
            begin
                if (cont_ident)
                begin
                    kw_next = kw_step;
                    if (rlen_reg != {OFFSET_BITS{1'b1}})
                        rlen_next = rlen_reg + 1'b1;
                end
                else if (cont_num)
                begin
                    // x*10 as two shifts; wraps at the value width
                    accum_next = VALUE_BITS'(accum_reg << 3) + VALUE_BITS'(accum_reg << 1)
                               + VALUE_BITS'(char_reg[3:0]);
                end
                else
                begin
                    mode_next = MODE_IDLE;
                    if (is_letter)
                    begin
                        mode_next  = MODE_IDENT;
                        sline_next = line_reg;
                        scol_next  = col_reg;
                        soff_next  = pos_reg;
                        rlen_next  = OFFSET_BITS'(1);
                        kw_next    = (char_reg == "i") ? KW_I :
                                     (char_reg == "r") ? KW_R : KW_DEAD;
                    end
                    else if (is_digit)
                    begin
                        mode_next  = MODE_NUMBER;
                        sline_next = line_reg;
                        scol_next  = col_reg;
                        accum_next = VALUE_BITS'(char_reg[3:0]);
                    end
                    else if (is_bad)
                    begin
                        halted_next = 1'b1;
                    end
                end

                // every non-end byte advances position
                pos_next = pos_reg + 1'b1;
                if (char_reg == CH_LF)
                begin
                    if (line_reg != {LINE_BITS{1'b1}})
                        line_next = line_reg + 1'b1;
                    col_next = COL_BITS'(1);
                end
                else if (col_reg != {COL_BITS{1'b1}})
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            halted_reg <= 1'b0;
            pos_reg    <= '0;
            line_reg   <= LINE_BITS'(1);
            col_reg    <= COL_BITS'(1);
            sline_reg  <= LINE_BITS'(1);
            scol_reg   <= COL_BITS'(1);
            soff_reg   <= '0;
            rlen_reg   <= '0;
            accum_reg  <= '0;
            kw_reg     <= KW_DEAD;
        end
        else
        begin
            mode_reg   <= mode_next;
            halted_reg <= halted_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            sline_reg  <= sline_next;
            scol_reg   <= scol_next;
            soff_reg   <= soff_next;
            rlen_reg   <= rlen_next;
            accum_reg  <= accum_next;
            kw_reg     <= kw_next;
        end
    end

    // ---------------- result queue ----------------
    assign pop        = out_valid && !out_stall;
    assign wr_ptr_inc = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(has_flush) + PTR_W'(has_second);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(has_flush) + CNT_W'(has_second) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (has_flush)
            q_mem[wr_ptr_reg] <= flush_tok;
        if (has_second)
            q_mem[has_flush ? wr_ptr_inc : wr_ptr_reg] <= second_tok;
    end

    assign out_valid     = (count_reg != '0);
    assign token_kind    = q_mem[rd_ptr_reg].kind;
    assign token_line    = q_mem[rd_ptr_reg].line;
    assign token_column  = q_mem[rd_ptr_reg].col;
    assign literal_value = q_mem[rd_ptr_reg].value;
    assign ident_start   = q_mem[rd_ptr_reg].start;
    assign ident_length  = q_mem[rd_ptr_reg].length;
    assign bad_char      = q_mem[rd_ptr_reg].bad;
    assign last_of_run   = q_mem[rd_ptr_reg].last;

endmodule

/* sv/cst_checker.sv */
// Port-level checks for the C subset tokenizer, bound to the top level.
// Depends on cst_pkg and c_subset_tokenizer_core_defines.svh.
`include "c_subset_tokenizer_core_defines.svh"

module cst_checker
    import cst_pkg::*;
#(
    parameter int LINE_BITS   = CST_LINE_BITS,
    parameter int COL_BITS    = CST_COL_BITS,
    parameter int OFFSET_BITS = CST_OFFSET_BITS,
    parameter int VALUE_BITS  = CST_VALUE_BITS
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [3:0]             token_kind,
    input logic [LINE_BITS-1:0]   token_line,
    input logic [COL_BITS-1:0]    token_column,
    input logic [VALUE_BITS-1:0]  literal_value,
    input logic [OFFSET_BITS-1:0] ident_start,
    input logic [OFFSET_BITS-1:0] ident_length,
    input logic [7:0]             bad_char,
    input logic                   last_of_run
);

    localparam int OUT_W = 4 + LINE_BITS + COL_BITS + VALUE_BITS + 2 * OFFSET_BITS + 9;

    logic [OUT_W-1:0] out_word;
    logic             out_take;
    logic             stop_shown;
    logic             end_shown;

    assign out_word   = {token_kind, token_line, token_column, literal_value,
                         ident_start, ident_length, bad_char, last_of_run};
    assign out_take   = out_valid && !out_stall;
    assign stop_shown = (token_kind == TKN_END) || (token_kind == TKN_BAD);
    assign end_shown  = out_valid && (token_kind == TKN_END);

    `CST_ASSERT_ALWAYS(a_no_out_in_reset, clk, !rst_n |=> !out_valid, "item after reset edge")

    `CST_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled item changed")

    `CST_ASSERT(a_silent_after_stop, clk, rst_n, out_take && stop_shown |=> !out_valid, "item after stop")

    `CST_ASSERT(a_eof_last, clk, rst_n, end_shown |-> last_of_run && literal_value == '0, "end token malformed")

    `CST_ASSERT(a_bad_only_err, clk, rst_n, out_valid && token_kind != TKN_BAD |-> bad_char == 8'h00, "stray bad byte")

endmodule

bind c_subset_tokenizer_core cst_checker #(
    .LINE_BITS(LINE_BITS),
    .COL_BITS(COL_BITS),
    .OFFSET_BITS(OFFSET_BITS),
    .VALUE_BITS(VALUE_BITS)
) u_cst_checker (.*);
